// ----- design/prime_stream_filter_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the prime stream filter
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef PRIME_STREAM_FILTER_UNIT_ASSERT_SVH
`define PRIME_STREAM_FILTER_UNIT_ASSERT_SVH

// Next-cycle implication, off while reset is asserted
`define PSF_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_i) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Same-cycle implication, off while reset is asserted
`define PSF_ASSERT_SAME(lbl, clk_i, rst_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_i) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication that also holds across reset
`define PSF_ASSERT_RESET(lbl, clk_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) (ante) |=> (cons)) \
    else $error("reset check failed");

`endif

// ----- design/psf_pkg.sv -----
// ----------------------------------------------------------------------------
// Prime stream filter package
// Payload types and fixed field widths of the input and result channels.
// ----------------------------------------------------------------------------
package psf_pkg;

  localparam int VALUE_W = 16;
  localparam int SLOT_W  = 8;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] prime_value;
    logic [SLOT_W-1:0]  slot;
  } out_item_t;

endpackage

// ----- design/prime_stream_filter_unit.sv -----
// Divisors tried: 2, then odd divisors up to floor(sqrt(value)), on the value cut
// to W = min(VALUE_BITS, 16) bits. One item at a time; a bit-serial remainder unit
// (one quotient bit per cycle) tests each divisor in turn.
// Results sit in an output register, so the next item is taken while one waits.
// Synchronous active-low reset clears the prime count, the sequencer and out_valid.
// ----------------------------------------------------------------------------
// Prime stream filter
// Trial-division primality test over a value stream; passes primes on with
// their slot from a saturating running count that clears after the last item.
// ----------------------------------------------------------------------------
module prime_stream_filter_unit #(
  parameter int VALUE_BITS = 16,
  parameter int MAX_PRIMES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  psf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output psf_pkg::out_item_t out_data
);
  import psf_pkg::*;

  localparam int VW    = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int CW    = $clog2(MAX_PRIMES);
  localparam int CNT_W = $clog2(VW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_EVAL,
    S_DONE
  } state_t;

  state_t          state_r, state_nxt;
  logic [VW-1:0]   n_r, n_nxt;
  logic            last_r, last_nxt;
  logic [VW-1:0]   d_r, d_nxt;
  logic [VW-1:0]   rem_r, rem_nxt;
  logic [VW-1:0]   shreg_r, shreg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  logic [2*VW-1:0] sq;
  logic [VW:0]     trial;
  logic            trial_ge;

  assign sq       = d_r * d_r;
  assign trial    = {rem_r, shreg_r[VW-1]};
  assign trial_ge = trial >= {1'b0, d_r};

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    last_nxt      = last_r;
    d_nxt         = d_r;
    rem_nxt       = rem_r;
    shreg_nxt     = shreg_r;
    cnt_nxt       = cnt_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt     = in_data.value[VW-1:0];
          last_nxt  = in_data.last;
          d_nxt     = VW'(2);
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (n_r < VW'(2)) begin
          if (last_r) count_nxt = '0;
          state_nxt = S_IDLE;
        end else if (sq > (2*VW)'(n_r)) begin
          state_nxt = S_DONE;
        end else begin
          rem_nxt   = '0;
          shreg_nxt = n_r;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // one restoring-division step per cycle, MSB of value first
        rem_nxt   = trial_ge ? VW'(trial - {1'b0, d_r}) : trial[VW-1:0];
        shreg_nxt = shreg_r << 1;
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(VW-1)) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (rem_r == '0) begin
          // divisor found: drop the item
          if (last_r) count_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          d_nxt     = (d_r == VW'(2)) ? VW'(3) : d_r + VW'(2);
          state_nxt = S_CHECK;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.prime_value = VALUE_W'(n_r);
          out_data_nxt.slot        = SLOT_W'(count_r);
          out_valid_nxt            = 1'b1;
          if (last_r) begin
            count_nxt = '0;
          end else if (count_r < CW'(MAX_PRIMES-1)) begin
            count_nxt = count_r + CW'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    last_r     <= last_nxt;
    d_r        <= d_nxt;
    rem_r      <= rem_nxt;
    shreg_r    <= shreg_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/psf_checker.sv -----
// ----------------------------------------------------------------------------
// Prime stream filter port checker
// Watches the top-level ports over time; bound to every instance.
// ----------------------------------------------------------------------------
`include "prime_stream_filter_unit_assert.svh"

module psf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input psf_pkg::out_item_t out_data
);
  import psf_pkg::*;

  // a stalled result holds
  `PSF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable(out_data))

  // the block goes busy right after taking an item
  `PSF_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_valid && !in_stall, in_stall)

  // a new result only appears at the end of a test
  `PSF_ASSERT_SAME(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall))

  // reset leaves the block idle and empty
  `PSF_ASSERT_RESET(a_reset_idle, clk, !rst_n, !out_valid && !in_stall)

endmodule

bind prime_stream_filter_unit psf_checker u_psf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
